### rtl/core/mah_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer average and heading package
// Shared constants, lookup table, state type and controller command bundle.
// ----------------------------------------------------------------------------
package mah_pkg;

	// Number of CORDIC vectoring steps. Anything above the table length runs as
	// the full table.
	localparam int CordicSteps = 16;
	localparam int MaxSteps    = 24;
	localparam int NumSteps    = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
	localparam int StepW       = (NumSteps > 1) ? $clog2(NumSteps) : 1;

	localparam int BlockLen = 5;
	localparam int CountW   = 3;

	// Field widths.
	localparam int AxisW   = 13;
	localparam int ZW      = 15;
	localparam int SumXyW  = 16;
	localparam int SumZW   = 18;
	localparam int YawW    = 19;

	// CORDIC datapath: operands are scaled by 2^20, angles are Q24 radians.
	localparam int Prescale = 20;
	localparam int CordicW  = 36;
	localparam int AngW     = 28;
	localparam logic signed [AngW-1:0] PiQ24 = AngW'(52707179);

	// Shared multiplier.
	localparam int MulAW = 27;
	localparam int MulBW = 28;
	localparam int ProdW = MulAW + MulBW;

	// Division by five: ceil(2^20 / 5), exact for magnitudes below 2^18.
	localparam int RecipFiveShift = 20;
	localparam logic [MulBW-1:0] RecipFive = MulBW'(209716);

	// Angle to millidegrees: round(A * 9000000 / (157 * 2^24)).
	localparam logic [MulBW-1:0] ConvNum   = MulBW'(9000000);
	localparam logic [ProdW-1:0] ConvBias  = ProdW'(157) << 23;
	localparam int ConvShift               = 24;
	// ceil(2^35 / 157), exact for quotients of magnitudes below 2^27.
	localparam logic [MulBW-1:0] RecipConv = MulBW'(218851837);
	localparam int RecipConvShift          = 35;
	localparam int YawMagW                 = 18;

	function automatic logic [23:0] atan_q24(input logic [4:0] idx);
		logic [23:0] r;
		unique case (idx)
			5'd0:  r = 24'd13176795;
			5'd1:  r = 24'd7778716;
			5'd2:  r = 24'd4110060;
			5'd3:  r = 24'd2086331;
			5'd4:  r = 24'd1047214;
			5'd5:  r = 24'd524117;
			5'd6:  r = 24'd262123;
			5'd7:  r = 24'd131069;
			5'd8:  r = 24'd65536;
			5'd9:  r = 24'd32768;
			5'd10: r = 24'd16384;
			5'd11: r = 24'd8192;
			5'd12: r = 24'd4096;
			5'd13: r = 24'd2048;
			5'd14: r = 24'd1024;
			5'd15: r = 24'd512;
			5'd16: r = 24'd256;
			5'd17: r = 24'd128;
			5'd18: r = 24'd64;
			5'd19: r = 24'd32;
			5'd20: r = 24'd16;
			5'd21: r = 24'd8;
			5'd22: r = 24'd4;
			5'd23: r = 24'd2;
			default: r = 24'd0;
		endcase
		return r;
	endfunction

	typedef enum logic [3:0] {
		S_IDLE,
		S_AVG_X,
		S_AVG_Y,
		S_AVG_Z,
		S_CAP_Z,
		S_ITER,
		S_CONV_A,
		S_CONV_U,
		S_CONV_B,
		S_FINISH
	} mah_state_t;

	typedef enum logic [2:0] {
		MUL_SUM_X,
		MUL_SUM_Y,
		MUL_SUM_Z,
		MUL_ANG,
		MUL_U
	} mah_mul_sel_t;

	typedef struct packed {
		logic             acc;
		logic             clear;
		mah_mul_sel_t     mul_sel;
		logic             cap_x;
		logic             cap_y;
		logic             cap_z;
		logic             cordic_init;
		logic             cordic_step;
		logic [StepW-1:0] step_idx;
		logic             cap_u;
		logic             load_out;
	} mah_cmd_t;

endpackage

### rtl/core/mah_ctrl.sv
// ----------------------------------------------------------------------------
// Magnetometer average and heading controller
// Counts readings per block and sequences the averaging, CORDIC and scaling.
// ----------------------------------------------------------------------------
module mah_ctrl
	import mah_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output mah_cmd_t cmd
);

	mah_state_t       state_q, state_d;
	logic [CountW-1:0] count_q;
	logic [StepW-1:0]  step_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;
	logic              last_step;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign last_step = (step_q == StepW'(NumSteps - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (count_q == CountW'(BlockLen - 1)) begin
					count_q <= '0;
				end else begin
					count_q <= count_q + CountW'(1);
				end
			end
			if (state_q == S_CAP_Z) begin
				step_q <= '0;
			end else if (state_q == S_ITER) begin
				step_q <= step_q + StepW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_SUM_X;
		cmd.step_idx = step_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.acc = accept;
				if (accept && count_q == CountW'(BlockLen - 1)) begin
					state_d = S_AVG_X;
				end
			end
			S_AVG_X: begin
				cmd.mul_sel = MUL_SUM_X;
				state_d     = S_AVG_Y;
			end
			S_AVG_Y: begin
				cmd.mul_sel = MUL_SUM_Y;
				cmd.cap_x   = 1'b1;
				state_d     = S_AVG_Z;
			end
			S_AVG_Z: begin
				cmd.mul_sel = MUL_SUM_Z;
				cmd.cap_y   = 1'b1;
				state_d     = S_CAP_Z;
			end
			S_CAP_Z: begin
				cmd.cap_z       = 1'b1;
				cmd.cordic_init = 1'b1;
				state_d         = S_ITER;
			end
			S_ITER: begin
				cmd.cordic_step = 1'b1;
				if (last_step) begin
					state_d = S_CONV_A;
				end
			end
			S_CONV_A: begin
				cmd.mul_sel = MUL_ANG;
				state_d     = S_CONV_U;
			end
			S_CONV_U: begin
				cmd.cap_u = 1'b1;
				state_d   = S_CONV_B;
			end
			S_CONV_B: begin
				cmd.mul_sel = MUL_U;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				// Keep the final product steady while the output register is busy.
				cmd.mul_sel = MUL_U;
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/mah_dp.sv
// ----------------------------------------------------------------------------
// Magnetometer average and heading datapath
// Accumulators, shared multiplier, CORDIC vectoring unit and output register.
// ----------------------------------------------------------------------------
module mah_dp
	import mah_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  mah_cmd_t               cmd,
	input  logic [7:0]             x_low_byte,
	input  logic [7:0]             x_high_byte,
	input  logic [7:0]             y_low_byte,
	input  logic [7:0]             y_high_byte,
	input  logic [7:0]             z_low_byte,
	input  logic [7:0]             z_high_byte,
	output logic signed [AxisW-1:0] avg_x,
	output logic signed [AxisW-1:0] avg_y,
	output logic signed [ZW-1:0]    avg_z,
	output logic signed [YawW-1:0]  yaw_millideg
);

	logic signed [SumXyW-1:0] sum_x_q, sum_y_q;
	logic signed [SumZW-1:0]  sum_z_q;
	logic signed [AxisW-1:0]  vx, vy;
	logic signed [ZW-1:0]     vz;

	logic [SumXyW-1:0] abs_x, abs_y;
	logic [SumZW-1:0]  abs_z;
	logic [AngW-1:0]   abs_ang;
	logic [MulAW-1:0]  mul_a;
	logic [MulBW-1:0]  mul_b;
	logic [ProdW-1:0]  prod_q;
	logic [ProdW-1:0]  conv_t;
	logic [MulAW-1:0]  u_q;

	logic [ZW-1:0]            quot;
	logic signed [ZW:0]       quot_s;
	logic signed [AxisW-1:0]  avg_x_q, avg_y_q;
	logic signed [ZW-1:0]     avg_z_q;

	logic signed [CordicW-1:0] ax_w, ay_w;
	logic signed [CordicW-1:0] xx_q, yy_q, dx, dy;
	logic signed [AngW-1:0]    ang_q, atan_step;

	logic [YawMagW-1:0]       yaw_mag;
	logic signed [YawW-1:0]   yaw_pos;
	logic signed [YawW-1:0]   yaw_val;
	logic                     zero_vec;

	logic signed [AxisW-1:0]  out_x_q, out_y_q;
	logic signed [ZW-1:0]     out_z_q;
	logic signed [YawW-1:0]   out_yaw_q;

	// Masked register pairs, already divided exactly by eight or two.
	assign vx = {x_high_byte, x_low_byte[7:3]};
	assign vy = {y_high_byte, y_low_byte[7:3]};
	assign vz = {z_high_byte, z_low_byte[7:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (cmd.clear) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (cmd.acc) begin
			sum_x_q <= sum_x_q + SumXyW'(vx);
			sum_y_q <= sum_y_q + SumXyW'(vy);
			sum_z_q <= sum_z_q + SumZW'(vz);
		end
	end

	assign abs_x   = sum_x_q[SumXyW-1] ? SumXyW'(-sum_x_q) : SumXyW'(sum_x_q);
	assign abs_y   = sum_y_q[SumXyW-1] ? SumXyW'(-sum_y_q) : SumXyW'(sum_y_q);
	assign abs_z   = sum_z_q[SumZW-1] ? SumZW'(-sum_z_q) : SumZW'(sum_z_q);
	assign abs_ang = ang_q[AngW-1] ? AngW'(-ang_q) : AngW'(ang_q);

	always_comb begin
		case (cmd.mul_sel)
			MUL_SUM_X: begin
				mul_a = MulAW'(abs_x);
				mul_b = RecipFive;
			end
			MUL_SUM_Y: begin
				mul_a = MulAW'(abs_y);
				mul_b = RecipFive;
			end
			MUL_SUM_Z: begin
				mul_a = MulAW'(abs_z);
				mul_b = RecipFive;
			end
			MUL_ANG: begin
				mul_a = abs_ang[MulAW-1:0];
				mul_b = ConvNum;
			end
			MUL_U: begin
				mul_a = u_q;
				mul_b = RecipConv;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
	end

	// Quotient by five of the magnitude, sign restored from the sum.
	assign quot   = prod_q[RecipFiveShift +: ZW];
	assign quot_s = {1'b0, quot};

	always_ff @(posedge clk) begin
		if (cmd.cap_x) begin
			avg_x_q <= AxisW'(sum_x_q[SumXyW-1] ? -quot_s : quot_s);
		end
		if (cmd.cap_y) begin
			avg_y_q <= AxisW'(sum_y_q[SumXyW-1] ? -quot_s : quot_s);
		end
		if (cmd.cap_z) begin
			avg_z_q <= ZW'(sum_z_q[SumZW-1] ? -quot_s : quot_s);
		end
	end

	// CORDIC vectoring of (avg_y, -avg_x).
	assign ax_w = {{(CordicW-AxisW-Prescale){avg_x_q[AxisW-1]}}, avg_x_q,
		{Prescale{1'b0}}};
	assign ay_w = {{(CordicW-AxisW-Prescale){avg_y_q[AxisW-1]}}, avg_y_q,
		{Prescale{1'b0}}};
	assign dx        = yy_q >>> cmd.step_idx;
	assign dy        = xx_q >>> cmd.step_idx;
	assign atan_step = AngW'(atan_q24(5'(cmd.step_idx)));

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			if (avg_y_q[AxisW-1]) begin
				// Left half plane: turn by a half circle first.
				xx_q  <= -ay_w;
				yy_q  <= ax_w;
				ang_q <= (avg_x_q <= 0) ? PiQ24 : -PiQ24;
			end else begin
				xx_q  <= ay_w;
				yy_q  <= -ax_w;
				ang_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			if (yy_q > 0) begin
				xx_q  <= xx_q + dx;
				yy_q  <= yy_q - dy;
				ang_q <= ang_q + atan_step;
			end else begin
				xx_q  <= xx_q - dx;
				yy_q  <= yy_q + dy;
				ang_q <= ang_q - atan_step;
			end
		end
	end

	// Rounded scaling: first the shift by 2^24, then the division by 157.
	assign conv_t = prod_q + ConvBias;

	always_ff @(posedge clk) begin
		if (cmd.cap_u) begin
			u_q <= conv_t[ConvShift +: MulAW];
		end
	end

	assign yaw_mag  = prod_q[RecipConvShift +: YawMagW];
	assign yaw_pos  = {1'b0, yaw_mag};
	assign zero_vec = (avg_x_q == '0) && (avg_y_q == '0);

	always_comb begin
		if (zero_vec) begin
			yaw_val = '0;
		end else if (ang_q[AngW-1]) begin
			yaw_val = -yaw_pos;
		end else begin
			yaw_val = yaw_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_x_q   <= avg_x_q;
			out_y_q   <= avg_y_q;
			out_z_q   <= avg_z_q;
			out_yaw_q <= yaw_val;
		end
	end

	assign avg_x        = out_x_q;
	assign avg_y        = out_y_q;
	assign avg_z        = out_z_q;
	assign yaw_millideg = out_yaw_q;

endmodule

### rtl/core/magnetometer_average_heading_top.sv
// ----------------------------------------------------------------------------
// Magnetometer average and heading, top level
// Averages blocks of five magnetometer readings and reports the heading.
// ----------------------------------------------------------------------------
// Each input word carries one reading as six raw register bytes. The unused
// low bits are dropped, each pair becomes a signed word, and the values are
// summed. Every fifth word yields one output word: the three block means,
// truncated toward zero, and the heading atan2(-x, y) in millidegrees.
// A word is taken on a rising edge with in_valid high and in_stall low; the
// output word is taken with out_valid high and out_stall low.
// The first four words of a block are taken one per cycle. The fifth word
// starts the block computation, which is paced by the iterative CORDIC
// loop and the single shared multiplier used in turn for the means and the
// angle scaling; the input is stalled during that time. The output word is
// valid from the edge that ends the computation.
// A finished word sits in the output register while
// the next block is gathered; if it is still stalled when the next block
// ends, the block waits in its final state until the register frees up.
// Reset clears the sums, the reading count and the output valid flag.
// ----------------------------------------------------------------------------
module magnetometer_average_heading_top
	import mah_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              x_low_byte,
	input  logic [7:0]              x_high_byte,
	input  logic [7:0]              y_low_byte,
	input  logic [7:0]              y_high_byte,
	input  logic [7:0]              z_low_byte,
	input  logic [7:0]              z_high_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [AxisW-1:0] avg_x,
	output logic signed [AxisW-1:0] avg_y,
	output logic signed [ZW-1:0]    avg_z,
	output logic signed [YawW-1:0]  yaw_millideg
);

	// Command bundle from the sequencer to the datapath.
	mah_cmd_t cmd;

	mah_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath holds the sums, the multiplier, the CORDIC registers and
	// the output register.
	mah_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.x_low_byte   (x_low_byte),
		.x_high_byte  (x_high_byte),
		.y_low_byte   (y_low_byte),
		.y_high_byte  (y_high_byte),
		.z_low_byte   (z_low_byte),
		.z_high_byte  (z_high_byte),
		.avg_x        (avg_x),
		.avg_y        (avg_y),
		.avg_z        (avg_z),
		.yaw_millideg (yaw_millideg)
	);

endmodule
